// ----- design/ncd_pkg.sv -----
// ----------------------------------------------------------------------------
// Negative cycle detector package
// Shared word types, command codes and sizes of the detector core.
// ----------------------------------------------------------------------------
package ncd_pkg;

    localparam int MaxVertices = 256;
    localparam int MaxEdges    = 1024;
    localparam int DistBits    = 48;

    localparam int VBits = $clog2(MaxVertices);
    localparam int EBits = $clog2(MaxEdges);

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         from_vertex;
        logic [7:0]         to_vertex;
        logic signed [15:0] edge_weight;
    } t_in_word;

    typedef struct packed {
        logic negative_cycle;
        logic edges_dropped;
    } t_out_word;

endpackage

// ----- design/negative_cycle_detector_core.sv -----
// ----------------------------------------------------------------------------
// Negative cycle detector core
// Queue-based Bellman-Ford over a loaded edge table, reports reachable
// negative cycles from vertex 0.
// ----------------------------------------------------------------------------
// Usage: input words carry a command. Clear and add-edge words are taken one
// per cycle and give no result. A run word starts a search from vertex 0 over
// the first vertex_count vertices and gives one output word with the cycle
// flag and the dropped-edge flag. The configuration channel writes
// vertex_count and is always ready; write it only while the core is idle.
// Each dequeue steps through the dequeue, queue-read and distance-read states,
// then scans the whole edge memory through its single read port, one edge at
// a time, with a read and a check state per edge and a relax state per match.
// With an empty table no edge is scanned and the output word is set on empty.
// While a run is in progress o_in_stall is high. A finished word waits in
// the output register while the receiver stalls; clear and add words are
// still taken, but a new run word waits until the output register is free.
// Reset empties the edge table, clears the overflow flag, sets vertex_count
// to 1 and leaves the output register empty. No memory clearing pass is
// needed: per-run state uses valid bits held in flip-flops.
// ----------------------------------------------------------------------------
module negative_cycle_detector_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ncd_pkg::t_in_word     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ncd_pkg::t_out_word    o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [8:0]            i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DEQ   = 7'b0000010,
        S_VLD   = 7'b0000100,
        S_VDIST = 7'b0001000,
        S_EREAD = 7'b0010000,
        S_ECHK  = 7'b0100000,
        S_RELAX = 7'b1000000
    } t_state;

    localparam int VB = ncd_pkg::VBits;
    localparam int EB = ncd_pkg::EBits;
    localparam int DB = ncd_pkg::DistBits;

    t_state r_state;
    logic [8:0] r_vcount;
    logic [EB:0] r_edge_total;
    logic r_overflow;
    logic r_out_valid;
    ncd_pkg::t_out_word r_out_data;

    // Memories.
    logic [31:0]          edge_mem [ncd_pkg::MaxEdges];
    logic signed [DB-1:0] dist_mem [ncd_pkg::MaxVertices];
    logic [8:0]           cnt_mem  [ncd_pkg::MaxVertices];
    logic [VB-1:0]        q_mem    [ncd_pkg::MaxVertices];

    logic [31:0]          r_edge_rd;
    logic signed [DB-1:0] r_dist_rd;
    logic [8:0]           r_cnt_rd;
    logic [VB-1:0]        r_q_rd;

    logic [ncd_pkg::MaxVertices-1:0] r_dvalid;
    logic [ncd_pkg::MaxVertices-1:0] r_mark;

    logic [VB-1:0]        r_head;
    logic [8:0]           r_qlen;
    logic [VB-1:0]        r_v;
    logic signed [DB-1:0] r_dv;
    logic [EB:0]          r_e;
    logic [8:0]           r_n;

    logic accept;
    logic [VB-1:0] dist_raddr;
    logic [VB-1:0] tail;
    logic [VB-1:0] e_src, e_dst;
    logic signed [15:0] e_w;
    logic signed [DB:0] sum;
    logic signed [DB-1:0] cand;
    logic improve;
    logic [8:0] new_cnt;
    logic [EB:0] e_next;
    logic [8:0] n_clamped;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_in_stall  = (r_state != S_IDLE) ||
                         (r_out_valid && i_in_data.command == ncd_pkg::CMD_RUN);
    assign accept = i_in_valid && !o_in_stall;

    assign tail  = r_head + r_qlen[VB-1:0];
    assign e_src = r_edge_rd[31:24];
    assign e_dst = r_edge_rd[23:16];
    assign e_w   = r_edge_rd[15:0];
    assign e_next = r_e + 1'b1;

    assign n_clamped = (r_vcount == 9'd0) ? 9'd1 :
                       (r_vcount > 9'(ncd_pkg::MaxVertices)) ? 9'(ncd_pkg::MaxVertices) :
                       r_vcount;

    // Saturating add of the edge weight to the source distance.
    assign sum = {r_dv[DB-1], r_dv} + {{(DB+1-16){e_w[15]}}, e_w};
    always_comb begin
        if (sum[DB] != sum[DB-1]) begin
            cand = sum[DB] ? {1'b1, {(DB-1){1'b0}}} : {1'b0, {(DB-1){1'b1}}};
        end else begin
            cand = sum[DB-1:0];
        end
    end

    assign improve = !r_dvalid[e_dst] || (cand < r_dist_rd);
    // A vertex that is not reached has never been enqueued.
    assign new_cnt = (r_dvalid[e_dst] ? r_cnt_rd : 9'd0) + 9'd1;

    assign dist_raddr = (r_state == S_VLD) ? r_q_rd : e_dst;

    always_ff @(posedge i_clk) begin
        r_edge_rd <= edge_mem[r_e[EB-1:0]];
        r_dist_rd <= dist_mem[dist_raddr];
        r_cnt_rd  <= cnt_mem[dist_raddr];
        r_q_rd    <= q_mem[r_head];
        if (accept && i_in_data.command == ncd_pkg::CMD_ADD &&
            !r_edge_total[EB]) begin
            edge_mem[r_edge_total[EB-1:0]] <= {i_in_data.from_vertex,
                                               i_in_data.to_vertex,
                                               i_in_data.edge_weight};
        end
        if (accept && i_in_data.command == ncd_pkg::CMD_RUN) begin
            dist_mem[0] <= '0;
            cnt_mem[0]  <= 9'd1;
            q_mem[0]    <= '0;
        end else if (r_state == S_RELAX && improve) begin
            dist_mem[e_dst] <= cand;
            if (!r_mark[e_dst]) begin
                cnt_mem[e_dst] <= new_cnt;
                q_mem[tail]    <= e_dst;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_vcount     <= 9'd1;
            r_edge_total <= '0;
            r_overflow   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_mark       <= '0;
            r_dvalid     <= '0;
            r_qlen       <= '0;
            r_head       <= '0;
            r_e          <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_vcount <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_in_data.command)
                            ncd_pkg::CMD_CLEAR: begin
                                r_edge_total <= '0;
                                r_overflow   <= 1'b0;
                            end
                            ncd_pkg::CMD_ADD: begin
                                if (r_edge_total[EB]) begin
                                    r_overflow <= 1'b1;
                                end else begin
                                    r_edge_total <= r_edge_total + 1'b1;
                                end
                            end
                            ncd_pkg::CMD_RUN: begin
                                // Start: vertex 0 reached at distance 0, queued once.
                                r_n      <= n_clamped;
                                r_dvalid <= {{(ncd_pkg::MaxVertices-1){1'b0}}, 1'b1};
                                r_mark   <= {{(ncd_pkg::MaxVertices-1){1'b0}}, 1'b1};
                                r_head   <= '0;
                                r_qlen   <= 9'd1;
                                r_state  <= S_DEQ;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DEQ: begin
                    if (r_qlen == 9'd0) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= '{negative_cycle: 1'b0, edges_dropped: r_overflow};
                        r_mark      <= '0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_VLD;
                    end
                end
                S_VLD: begin
                    r_v           <= r_q_rd;
                    r_mark[r_q_rd] <= 1'b0;
                    r_head        <= r_head + 1'b1;
                    r_qlen        <= r_qlen - 9'd1;
                    r_state       <= S_VDIST;
                end
                S_VDIST: begin
                    r_dv    <= r_dist_rd;
                    r_e     <= '0;
                    r_state <= (r_edge_total == '0) ? S_DEQ : S_EREAD;
                end
                S_EREAD: begin
                    r_state <= S_ECHK;
                end
                S_ECHK: begin
                    if (e_src == r_v && {1'b0, e_dst} < r_n) begin
                        r_state <= S_RELAX;
                    end else begin
                        r_e     <= e_next;
                        r_state <= (e_next == r_edge_total) ? S_DEQ : S_EREAD;
                    end
                end
                S_RELAX: begin
                    if (improve && !r_mark[e_dst] && new_cnt >= r_n) begin
                        // The vertex reaches its n-th enqueue, so a cycle is found.
                        r_out_valid <= 1'b1;
                        r_out_data  <= '{negative_cycle: 1'b1,
                                         edges_dropped: r_overflow};
                        r_mark      <= '0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_e     <= e_next;
                        r_state <= (e_next == r_edge_total) ? S_DEQ : S_EREAD;
                        if (improve) begin
                            r_dvalid[e_dst] <= 1'b1;
                            if (e_dst == r_v) begin
                                r_dv <= cand;
                            end
                            if (!r_mark[e_dst]) begin
                                r_mark[e_dst] <= 1'b1;
                                r_qlen        <= r_qlen + 9'd1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
